// ----- rtl/core/rfc_pkg.sv -----
// shared types, constants and helpers of the rgb fade channel controller
package rfc_pkg;

    localparam int NUM_CHANNELS_DEF = 5;
    localparam int SWITCH_FLAGS     = 5;

    localparam logic [7:0] RESET_ADDRESS = 8'd4;
    localparam logic [7:0] RESET_RED     = 8'd136;
    localparam logic [7:0] RESET_GREEN   = 8'd40;

    localparam logic [7:0] CMD_SWITCH = 8'd1;
    localparam logic [7:0] CMD_COLOR  = 8'd2;

    localparam logic REG_BUS_ADDRESS = 1'b0;

    typedef enum logic
    {
        KIND_COMMAND = 1'b0,
        KIND_TICK    = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } rgb_t;

    typedef struct packed
    {
        rgb_t level;
        logic at_target;
    } step_res_t;

    // one level moves one count toward its target
    function automatic logic [7:0] step_level(input logic [7:0] cur, input logic [7:0] tgt);
        logic [7:0] nxt;
        begin
            nxt = cur;
            if (cur < tgt)
            begin
                nxt = cur + 8'd1;
            end
            else if (cur > tgt)
            begin
                nxt = cur - 8'd1;
            end
            return nxt;
        end
    endfunction

endpackage

// ----- rtl/core/rfc_stepper.sv -----
// fade step of one channel: moves r, g and b toward the target and flags arrival
module rfc_stepper
    import rfc_pkg::*;
(
    input  rgb_t      cur,
    input  rgb_t      tgt,
    output step_res_t res
);

    rgb_t lvl;

    always_comb
    begin
        lvl.r         = step_level(cur.r, tgt.r);
        lvl.g         = step_level(cur.g, tgt.g);
        lvl.b         = step_level(cur.b, tgt.b);
        res.level     = lvl;
        res.at_target = (lvl.r == tgt.r) && (lvl.g == tgt.g) && (lvl.b == tgt.b);
    end

endmodule

// ----- rtl/core/rgb_fade_channel_controller.sv -----
// top level of the rgb fade channel controller
// path: a tick transfer is registered in the step stage, then in the output register
// throughput: one item per cycle while the output is not stalled; current levels live in
//   a one-port-read memory read at acceptance and written back as the step stage advances,
//   with a bypass register covering back-to-back ticks on the same channel
// reset: asynchronous, active low; targets return to r136 g40 b0, presets and
//   current levels to zero (per-entry valid bits), pointer to channel 0, address to 4
module rgb_fade_channel_controller
    import rfc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // dest_address, command_code, arg0, arg1, arg2, arg3, arg4 (lowest bit up)
    input  logic [55:0] s_tdata,
    // kind
    input  logic [0:0]  s_tuser,
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // channel[2:0], red, green, blue, at_target, relay_on, zero fill
    output logic [31:0] m_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int FLAG_CNT = (NUM_CHANNELS < SWITCH_FLAGS) ? NUM_CHANNELS : SWITCH_FLAGS;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

    // input transfer fields
    kind_t      kind;
    logic [7:0] dest_address;
    logic [7:0] command_code;
    logic [7:0] args [SWITCH_FLAGS];
    rgb_t       color_in;

    // configuration
    logic [7:0] bus_address_reg;
    logic [7:0] bus_address_next;
    logic       cfg_wr;

    // channel tables held in flops: switch commands touch up to SWITCH_FLAGS entries at once
    rgb_t preset_reg [NUM_CHANNELS];
    rgb_t target_reg [NUM_CHANNELS];

    // current levels memory with per-entry valid bits (unwritten reads as zero)
    rgb_t cur_mem [NUM_CHANNELS];
    rgb_t mem_rd_reg;
    logic [NUM_CHANNELS-1:0] cur_vld_reg;

    // round-robin pointer
    logic [CH_W-1:0] ptr_reg;
    logic [CH_W-1:0] ptr_next;

    // step stage
    logic            s2_valid_reg;
    logic            s2_valid_next;
    logic [CH_W-1:0] s2_ch_reg;
    logic            s2_vld_reg;
    logic            s2_fwd_reg;
    rgb_t            s2_fwd_data_reg;
    rgb_t            s2_cur;
    rgb_t            s2_tgt;
    step_res_t       s2_res;
    logic            relay;

    // output register
    logic            m_valid_reg;
    logic            m_valid_next;
    logic [31:0]     m_data_reg;
    logic [31:0]     m_data_next;

    // handshake
    logic accept;
    logic tick_acc;
    logic cmd_acc;
    logic out_free;
    logic s2_adv;
    logic color_ok;
    logic [CH_W-1:0] color_idx;

    // unpack the slave transfer
    always_comb
    begin
        kind         = kind_t'(s_tuser[0]);
        dest_address = s_tdata[7:0];
        command_code = s_tdata[15:8];
        for (int k = 0; k < SWITCH_FLAGS; k++)
        begin
            args[k] = s_tdata[16 + 8*k +: 8];
        end
        color_in.r = args[0];
        color_in.g = args[1];
        color_in.b = args[2];
    end

    // the step stage never holds while a command could change its target
    assign out_free = !m_valid_reg || m_tready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s_tready = !s2_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;
    assign tick_acc = accept && (kind == KIND_TICK);
    assign cmd_acc  = accept && (kind == KIND_COMMAND) && (dest_address == bus_address_reg);

    // colour command index check; anything at or past the channel count is dropped
    assign color_ok  = (args[3] < 8'(NUM_CHANNELS));
    assign color_idx = args[3][CH_W-1:0];

    // configuration port: single register, write on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BUS_ADDRESS);

    always_comb
    begin
        bus_address_next = bus_address_reg;
        if (cfg_wr)
        begin
            bus_address_next = pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_BUS_ADDRESS)
        begin
            prdata = {24'd0, bus_address_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_address_reg <= RESET_ADDRESS;
        end
        else
        begin
            bus_address_reg <= bus_address_next;
        end
    end

    // preset and target tables, updated as command transfers are accepted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                preset_reg[i] <= '0;
                target_reg[i] <= '{b: 8'd0, g: RESET_GREEN, r: RESET_RED};
            end
        end
        else if (cmd_acc)
        begin
            if (command_code == CMD_SWITCH)
            begin
                // each channel with a flag byte: its preset if the flag is on, else a zero target
                for (int i = 0; i < FLAG_CNT; i++)
                begin
                    if (args[i] != 8'd0)
                    begin
                        target_reg[i] <= preset_reg[i];
                    end
                    else
                    begin
                        target_reg[i] <= '0;
                    end
                end
            end
            else if ((command_code == CMD_COLOR) && color_ok)
            begin
                preset_reg[color_idx] <= color_in;
                target_reg[color_idx] <= color_in;
            end
        end
    end

    // pointer wraps after the last channel
    always_comb
    begin
        ptr_next = ptr_reg;
        if (tick_acc)
        begin
            if (ptr_reg == LAST_CH)
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + CH_W'(1);
            end
        end
    end

    // current levels memory: read at tick acceptance, written back by the step stage
    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            mem_rd_reg <= cur_mem[ptr_reg];
        end
        if (s2_adv)
        begin
            cur_mem[s2_ch_reg] <= s2_res.level;
        end
    end

    // bypass data: the write landing on the edge of the read is not seen by the memory
    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            s2_ch_reg       <= ptr_reg;
            s2_fwd_data_reg <= s2_res.level;
        end
    end

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (tick_acc)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            s2_valid_reg <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s2_fwd_reg   <= 1'b0;
            cur_vld_reg  <= '0;
        end
        else
        begin
            ptr_reg      <= ptr_next;
            s2_valid_reg <= s2_valid_next;
            if (tick_acc)
            begin
                s2_vld_reg <= cur_vld_reg[ptr_reg];
                s2_fwd_reg <= s2_adv && (s2_ch_reg == ptr_reg);
            end
            if (s2_adv)
            begin
                cur_vld_reg[s2_ch_reg] <= 1'b1;
            end
        end
    end

    // step stage: pick the freshest copy of the level, then step toward the target
    always_comb
    begin
        if (s2_fwd_reg)
        begin
            s2_cur = s2_fwd_data_reg;
        end
        else if (s2_vld_reg)
        begin
            s2_cur = mem_rd_reg;
        end
        else
        begin
            s2_cur = '0;
        end
        s2_tgt = target_reg[s2_ch_reg];
    end

    rfc_stepper u_stepper
    (
        .cur (s2_cur),
        .tgt (s2_tgt),
        .res (s2_res)
    );

    // relay follows the blue target of channel 1, absent in a one-channel build
    generate
        if (NUM_CHANNELS > 1)
        begin : g_relay
            assign relay = (target_reg[1].b != 8'd0);
        end
        else
        begin : g_no_relay
            assign relay = 1'b0;
        end
    endgenerate

    // output register
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (s2_adv)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {3'd0, relay, s2_res.at_target, s2_res.level.b,
                            s2_res.level.g, s2_res.level.r, 3'(s2_ch_reg)};
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- test/rgb_fade_channel_controller_tb.sv -----
// self-checking stream testbench for the rgb fade channel controller
`timescale 1ns / 100ps

module rgb_fade_channel_controller_tb;
    import rfc_pkg::*;

    localparam int CHANNELS         = NUM_CHANNELS_DEF;
    localparam int RESET_CYCLES     = 11;
    localparam int RANDOM_PER_PHASE = 360;
    localparam int SETTLE_CYCLES    = 6;
    localparam int HOLD_CYCLES      = 400;
    localparam int QUIET_LIMIT      = 3000;

    // byte offset of the own-address register
    localparam logic [2:0] BUS_ADDRESS_OFFSET = {REG_BUS_ADDRESS, 2'b00};

    // command bytes as they sit in s_tdata, destination in the lowest byte
    typedef struct packed
    {
        logic [4:0][7:0] arg;
        logic [7:0]      code;
        logic [7:0]      dest;
    } cmd_bytes_t;

    typedef struct packed
    {
        kind_t      kind;
        cmd_bytes_t bytes;
    } fade_item_t;

    // one tick report as it sits in m_tdata[28:0]
    typedef struct packed
    {
        logic       relay_on;
        logic       at_target;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [2:0] channel;
    } fade_result_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // predicted state of the block
    rgb_t       preset_lvl  [CHANNELS];
    rgb_t       target_lvl  [CHANNELS];
    rgb_t       current_lvl [CHANNELS];
    int         ch_ptr;
    logic [7:0] own_address;

    fade_item_t   pending_items[$];
    fade_result_t fade_expect[$];

    int   items_fed     = 0;
    int   items_taken   = 0;
    int   mismatches    = 0;
    int   quiet_cycles  = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic in_taken      = 1'b0;

    // receiver hold-off request and its countdown
    logic hold_trigger = 1'b0;
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;

    rgb_fade_channel_controller uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [7:0] level_toward(input logic [7:0] cur, input logic [7:0] tgt);
        if (cur < tgt)
        begin
            return cur + 8'd1;
        end
        if (cur > tgt)
        begin
            return cur - 8'd1;
        end
        return cur;
    endfunction

    task automatic reset_prediction();
        int i;
        for (i = 0; i < CHANNELS; i++)
        begin
            preset_lvl[i]  = '0;
            target_lvl[i]  = '{b: 8'd0, g: RESET_GREEN, r: RESET_RED};
            current_lvl[i] = '0;
        end
        ch_ptr      = 0;
        own_address = RESET_ADDRESS;
    endtask

    // applies one accepted item and, for a tick, queues the report it causes
    function automatic void predict_item(input fade_item_t it);
        fade_result_t res;
        int           i;
        int           ch;
        if (it.kind == KIND_COMMAND)
        begin
            if (it.bytes.dest != own_address)
            begin
                return;
            end
            if (it.bytes.code == CMD_SWITCH)
            begin
                for (i = 0; i < SWITCH_FLAGS && i < CHANNELS; i++)
                begin
                    target_lvl[i] = (it.bytes.arg[i] != 8'd0) ? preset_lvl[i] : rgb_t'('0);
                end
            end
            else if (it.bytes.code == CMD_COLOR && it.bytes.arg[3] < CHANNELS)
            begin
                ch = it.bytes.arg[3];
                preset_lvl[ch].r = it.bytes.arg[0];
                preset_lvl[ch].g = it.bytes.arg[1];
                preset_lvl[ch].b = it.bytes.arg[2];
                target_lvl[ch]   = preset_lvl[ch];
            end
            return;
        end
        ch = ch_ptr;
        current_lvl[ch].r = level_toward(current_lvl[ch].r, target_lvl[ch].r);
        current_lvl[ch].g = level_toward(current_lvl[ch].g, target_lvl[ch].g);
        current_lvl[ch].b = level_toward(current_lvl[ch].b, target_lvl[ch].b);
        res.channel   = 3'(ch);
        res.red       = current_lvl[ch].r;
        res.green     = current_lvl[ch].g;
        res.blue      = current_lvl[ch].b;
        res.at_target = (current_lvl[ch] == target_lvl[ch]);
        res.relay_on  = (CHANNELS > 1) && (target_lvl[1].b != 8'd0);
        fade_expect.push_back(res);
        ch_ptr = (ch + 1 >= CHANNELS) ? 0 : ch + 1;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result(input fade_result_t got);
        fade_result_t want;
        if (fade_expect.size() == 0)
        begin
            $error("tick report with nothing pending: channel %0d", got.channel);
            mismatches++;
            return;
        end
        want = fade_expect.pop_front();
        check_field("channel", 8'(want.channel), 8'(got.channel));
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("at_target", 8'(want.at_target), 8'(got.at_target));
        check_field("relay_on", 8'(want.relay_on), 8'(got.relay_on));
    endfunction

    function automatic fade_item_t make_cmd(input logic [7:0] dest, input logic [7:0] code,
                                            input logic [7:0] a0, input logic [7:0] a1,
                                            input logic [7:0] a2, input logic [7:0] a3,
                                            input logic [7:0] a4);
        fade_item_t it;
        it.kind  = KIND_COMMAND;
        it.bytes = '{arg: {a4, a3, a2, a1, a0}, code: code, dest: dest};
        return it;
    endfunction

    function automatic fade_item_t make_tick();
        fade_item_t it;
        it.kind  = KIND_TICK;
        it.bytes = 56'({$urandom(), $urandom()});
        return it;
    endfunction

    function automatic logic [7:0] color_level();
        // small levels so fades finish often, full range now and then
        if ($urandom_range(2) == 0)
        begin
            return 8'($urandom_range(255));
        end
        return 8'($urandom_range(12));
    endfunction

    // mostly ticks and well-formed commands to our address, some noise
    function automatic fade_item_t random_item(input logic [7:0] addr);
        fade_item_t it;
        int         pick;
        int         i;
        it   = make_cmd(addr, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom));
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            it = make_tick();
        end
        else if (pick < 65)
        begin
            it.bytes.code = CMD_SWITCH;
            for (i = 0; i < 5; i++)
            begin
                it.bytes.arg[i] = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            end
        end
        else if (pick < 85)
        begin
            it.bytes.code   = CMD_COLOR;
            it.bytes.arg[0] = color_level();
            it.bytes.arg[1] = color_level();
            it.bytes.arg[2] = color_level();
            it.bytes.arg[3] = 8'($urandom_range(CHANNELS - 1));
        end
        else if (pick < 90)
        begin
            // channel index past the last channel
            it.bytes.code   = CMD_COLOR;
            it.bytes.arg[3] = 8'($urandom_range(CHANNELS, 255));
        end
        else if (pick < 95)
        begin
            it.bytes.dest = addr ^ 8'($urandom_range(1, 255));
            if ($urandom_range(1) == 0)
            begin
                it.bytes.code = ($urandom_range(1) == 0) ? CMD_SWITCH : CMD_COLOR;
            end
        end
        else
        begin
            while (it.bytes.code == CMD_SWITCH || it.bytes.code == CMD_COLOR)
            begin
                it.bytes.code = 8'($urandom);
            end
        end
        return it;
    endfunction

    task automatic add_item(input fade_item_t it);
        pending_items.push_back(it);
        items_fed++;
    endtask

    task automatic wait_drain();
        while (items_taken != items_fed || fade_expect.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // write then read back the own-address register
    task automatic set_bus_address(input logic [7:0] value);
        logic [31:0] word;
        word       = $urandom;
        word[7:0]  = value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BUS_ADDRESS_OFFSET;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        own_address = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        check_field("bus_address", own_address, prdata[7:0]);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // sender: holds an item until its transfer, then maybe idles
    always @(negedge clk)
    begin : stream_feed
        fade_item_t nxt;
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.bytes;
                    s_tuser  <= nxt.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here so the block backs up its input
    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watches both transfers, predicts on input and checks on output
    always @(posedge clk)
    begin : stream_watch
        fade_item_t seen;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata[28:0]);
            end
            if (s_tvalid && s_tready)
            begin
                seen.kind  = kind_t'(s_tuser[0]);
                seen.bytes = s_tdata;
                predict_item(seen);
                items_taken <= items_taken + 1;
            end
        end
        else
        begin
            in_taken <= 1'b0;
        end
    end

    // ends a run in which transfers stop altogether
    always @(posedge clk)
    begin
        if (rst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        else
        begin
            quiet_cycles = 0;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : sequencer
        int         p;
        int         n;
        logic [7:0] addr_choice;
        reset_prediction();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset address
        add_item(make_tick());
        add_item(make_tick());
        add_item(make_cmd(8'd0, CMD_COLOR, 8'd9, 8'd9, 8'd9, 8'd0, 8'd0));
        add_item(make_cmd(8'd255, CMD_SWITCH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        add_item(make_cmd(RESET_ADDRESS, CMD_COLOR, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255));
        add_item(make_cmd(RESET_ADDRESS, CMD_COLOR, 8'd0, 8'd0, 8'd0, 8'd4, 8'd0));
        add_item(make_cmd(RESET_ADDRESS, CMD_COLOR, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0));
        add_item(make_cmd(RESET_ADDRESS, CMD_COLOR, 8'd7, 8'd7, 8'd7, 8'd5, 8'd0));
        add_item(make_cmd(RESET_ADDRESS, CMD_COLOR, 8'd7, 8'd7, 8'd7, 8'd255, 8'd0));
        add_item(make_cmd(RESET_ADDRESS, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1));
        add_item(make_cmd(RESET_ADDRESS, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1));
        add_item(make_cmd(RESET_ADDRESS, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        add_item(make_tick());
        add_item(make_tick());
        add_item(make_tick());
        add_item(make_tick());
        add_item(make_cmd(RESET_ADDRESS, CMD_SWITCH, 8'd255, 8'd0, 8'd1, 8'd128, 8'd0));
        add_item(make_tick());
        add_item(make_cmd(RESET_ADDRESS, CMD_SWITCH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        add_item(make_tick());
        add_item(make_cmd(RESET_ADDRESS, CMD_SWITCH, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        add_item(make_tick());
        add_item(make_tick());
        add_item(make_tick());
        wait_drain();

        // random phases, each under its own address and idling pattern
        for (p = 0; p < 4; p++)
        begin
            repeat (SETTLE_CYCLES) @(negedge clk);
            case (p)
                0:       addr_choice = 8'd0;
                1:       addr_choice = 8'd255;
                default: addr_choice = 8'($urandom_range(255));
            endcase
            set_bus_address(addr_choice);
            @(posedge clk);
            case (p)
                0:
                begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
                1:
                begin
                    send_idle_pct <= 51;
                    recv_idle_pct <= 0;
                end
                2:
                begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 51;
                end
                default:
                begin
                    send_idle_pct <= 33;
                    recv_idle_pct <= 33;
                end
            endcase
            for (n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                add_item(random_item(own_address));
            end
            if (p == 2)
            begin
                hold_trigger <= ~hold_trigger;
            end
            wait_drain();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
